[design/mcgs_pkg.sv]
// package for the maze cell grid store: types and constants
`timescale 1ns / 1ps
package mcgs_pkg;

  typedef enum logic [2:0] {
    ACT_WRITE  = 3'd0,
    ACT_SETCON = 3'd1,
    ACT_ADDCON = 3'd2,
    ACT_REMCON = 3'd3,
    ACT_SETPTH = 3'd4,
    ACT_READ   = 3'd5,
    ACT_NEXT   = 3'd6,
    ACT_NOP    = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    DIR_N    = 3'd0,
    DIR_E    = 3'd1,
    DIR_S    = 3'd2,
    DIR_W    = 3'd3,
    DIR_NONE = 3'd4,
    DIR_ALL  = 3'd5
  } dir_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD,
    ST_RDW,
    ST_NB_RD,
    ST_NB_WAIT,
    ST_NB_WR,
    ST_SRCH,
    ST_SRCH_W,
    ST_OUT
  } state_e;

  localparam logic [7:0] CON_MASK  = 8'h0F;
  localparam logic [7:0] PATH_MASK = 8'h30;
  localparam logic [1:0] PATH_EDGE = 2'd2;

  localparam int unsigned REG_WIDTH  = 0;
  localparam int unsigned REG_HEIGHT = 1;

  // bits for one direction code
  function automatic logic [3:0] dir_bits(logic [2:0] d);
    logic [3:0] r;
    r = 4'd0;
    case (d)
      DIR_N:   r = 4'b0001;
      DIR_E:   r = 4'b0010;
      DIR_S:   r = 4'b0100;
      DIR_W:   r = 4'b1000;
      DIR_ALL: r = 4'b1111;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

[design/maze_cell_grid_store_unit.sv]
// top level of the maze cell grid store: sequencer around cell and mark memories
// sequence: write actions read the cell, write it back, then read and rewrite each touched neighbor;
//   reads only read the cell, next-edge search reads one mark per scanned cell
// throughput: one item at a time; the single port of the cell memory sets the pace
// reset: after rst_ni rises a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells zeroes
//   both memories; no item is taken until it ends, size registers reset to 64
`timescale 1ns / 1ps
module maze_cell_grid_store_unit #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // action, cell_x, cell_y, new_value, direction, path_state, search_from_start
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cell_value, has_con, is_path, connected_mask, edge_found, edge_x, edge_y, coord_valid
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i
);
  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam int unsigned AW = XW + YW;
  localparam int unsigned NCELLS = MAX_WIDTH * MAX_HEIGHT;

  // size registers
  logic [6:0] gw_q, gh_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= 7'd64;
      gh_q <= 7'd64;
    end else if (cfg_we_i) begin
      if (cfg_index_i == 1'(mcgs_pkg::REG_WIDTH)) gw_q <= cfg_data_i;
      else gh_q <= cfg_data_i;
    end
  end

  // effective sizes, clamped
  logic [10:0] ew, eh;
  always_comb begin
    ew = (gw_q == 7'd0) ? 11'd1 : ((11'(gw_q) > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : 11'(gw_q));
    eh = (gh_q == 7'd0) ? 11'd1 : ((11'(gh_q) > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : 11'(gh_q));
  end

  // input fields
  logic [2:0] in_act, in_dir;
  logic [5:0] in_x, in_y;
  logic [7:0] in_nv;
  logic [1:0] in_ps;
  logic       in_from0;
  assign in_act   = s_axis_tdata[2:0];
  assign in_x     = s_axis_tdata[8:3];
  assign in_y     = s_axis_tdata[14:9];
  assign in_nv    = s_axis_tdata[22:15];
  assign in_dir   = s_axis_tdata[25:23];
  assign in_ps    = s_axis_tdata[27:26];
  assign in_from0 = s_axis_tdata[28];

  mcgs_pkg::state_e st_q, st_d;
  logic [2:0] act_q, act_d, dir_q, dir_d;
  logic [10:0] x_q, x_d, y_q, y_d;
  logic [7:0] nv_q, nv_d, cur_q, cur_d;
  logic [1:0] ps_q, ps_d;
  logic       vld_q, vld_d;
  logic [3:0] todo_q, todo_d, exists_q, exists_d;
  logic [1:0] nb_q, nb_d;
  logic [AW:0] clr_q, clr_d;
  logic [31:0] res_q, res_d;
  logic [31:0] out_q, out_d;
  logic        ov_q, ov_d;

  // memory ports
  logic          c_we, m_we;
  logic [AW-1:0] c_addr;
  logic [7:0]    c_wdata, c_rdata;
  logic          m_wdata;
  logic [0:0]    m_rdata;

  mcgs_ram #(.Width(8), .Depth(NCELLS)) u_cells (
    .clk_i, .we_i(c_we), .addr_i(c_addr), .wdata_i(c_wdata), .rdata_o(c_rdata)
  );
  mcgs_ram #(.Width(1), .Depth(NCELLS)) u_marks (
    .clk_i, .we_i(m_we), .addr_i(c_addr), .wdata_i(m_wdata), .rdata_o(m_rdata)
  );

  function automatic logic [AW-1:0] cidx(logic [10:0] cx, logic [10:0] cy);
    return AW'(cy[YW-1:0]) * AW'(MAX_WIDTH) + AW'(cx[XW-1:0]);
  endfunction

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= mcgs_pkg::ST_CLEAR;
      clr_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      clr_q <= clr_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; dir_q <= dir_d; x_q <= x_d; y_q <= y_d;
    nv_q <= nv_d; cur_q <= cur_d; ps_q <= ps_d; vld_q <= vld_d;
    todo_q <= todo_d; exists_q <= exists_d; nb_q <= nb_d; out_q <= out_d;
    res_q <= res_d;
  end

  assign s_axis_tready = (st_q == mcgs_pkg::ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

  logic [7:0] newv;
  logic [3:0] bits, chg, sel;
  logic [1:0] pick;
  logic [10:0] nx, ny;
  logic        hc;

  // sequencer
  always_comb begin
    st_d = st_q; act_d = act_q; dir_d = dir_q; x_d = x_q; y_d = y_q;
    nv_d = nv_q; cur_d = cur_q; ps_d = ps_q; vld_d = vld_q; todo_d = todo_q;
    exists_d = exists_q; nb_d = nb_q; clr_d = clr_q; out_d = out_q; res_d = res_q;
    ov_d = ov_q && !m_axis_tready;
    c_we = 1'b0; m_we = 1'b0; c_addr = cidx(x_q, y_q); c_wdata = '0; m_wdata = 1'b0;
    bits = mcgs_pkg::dir_bits(dir_q);
    newv = c_rdata; chg = '0; sel = '0; pick = '0; hc = 1'b0;
    nx = x_q; ny = y_q;
    case (act_q)
      mcgs_pkg::ACT_WRITE:  newv = nv_q;
      mcgs_pkg::ACT_SETCON: newv = (dir_q == mcgs_pkg::DIR_ALL) ? (c_rdata | mcgs_pkg::CON_MASK)
                                   : ((c_rdata & ~mcgs_pkg::CON_MASK) | {4'd0, bits});
      mcgs_pkg::ACT_ADDCON: newv = c_rdata | {4'd0, bits};
      mcgs_pkg::ACT_REMCON: newv = c_rdata & ~{4'd0, bits};
      mcgs_pkg::ACT_SETPTH: newv = (c_rdata & ~mcgs_pkg::PATH_MASK) | {2'd0, ps_q, 4'd0};
      default:              newv = c_rdata;
    endcase
    // lowest pending neighbor
    sel = todo_q & (~todo_q + 4'd1);
    pick = sel[1] ? 2'd1 : (sel[2] ? 2'd2 : (sel[3] ? 2'd3 : 2'd0));
    case (nb_q)
      2'd0:    ny = y_q - 11'd1;
      2'd1:    nx = x_q + 11'd1;
      2'd2:    ny = y_q + 11'd1;
      default: nx = x_q - 11'd1;
    endcase
    case (dir_q)
      mcgs_pkg::DIR_N, mcgs_pkg::DIR_E, mcgs_pkg::DIR_S, mcgs_pkg::DIR_W:
        hc = |(cur_q[3:0] & bits);
      mcgs_pkg::DIR_ALL: hc = &cur_q[3:0];
      default:           hc = ~|cur_q[3:0];
    endcase
    case (st_q)
      mcgs_pkg::ST_CLEAR: begin
        c_we = 1'b1; m_we = 1'b1; c_addr = clr_q[AW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW+1)'(NCELLS - 1)) st_d = mcgs_pkg::ST_IDLE;
      end
      mcgs_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          act_d = in_act; dir_d = in_dir; nv_d = in_nv; ps_d = in_ps;
          x_d = 11'(in_x); y_d = 11'(in_y);
          vld_d = (11'(in_x) < ew) && (11'(in_y) < eh);
          exists_d = {in_x != 6'd0, (11'(in_y) + 11'd1) < eh,
                      (11'(in_x) + 11'd1) < ew, in_y != 6'd0};
          if (in_act == mcgs_pkg::ACT_NEXT) begin
            if (in_from0) begin
              x_d = '0; y_d = '0;
            end else if ((11'(in_x) + 11'd1) >= ew) begin
              x_d = '0; y_d = 11'(in_y) + 11'd1;
            end else begin
              x_d = 11'(in_x) + 11'd1;
            end
            if (!in_from0 && !((11'(in_x) < ew) && (11'(in_y) < eh))) y_d = 11'd2047;
            st_d = mcgs_pkg::ST_SRCH;
          end else st_d = mcgs_pkg::ST_RD;
        end
      end
      mcgs_pkg::ST_RD: begin
        if (!vld_q || act_q == mcgs_pkg::ACT_NOP) begin
          res_d = '0; res_d[27] = vld_q; st_d = mcgs_pkg::ST_OUT;
        end else st_d = mcgs_pkg::ST_RDW;
      end
      mcgs_pkg::ST_RDW: begin
        // data of addressed cell is on c_rdata
        cur_d = newv;
        chg = (c_rdata[3:0] ^ newv[3:0]) & exists_q;
        if (act_q != mcgs_pkg::ACT_READ) begin
          c_we = 1'b1; c_wdata = newv;
          m_we = 1'b1; m_wdata = (newv[5:4] == mcgs_pkg::PATH_EDGE);
          todo_d = chg;
        end else todo_d = '0;
        st_d = mcgs_pkg::ST_NB_RD;
      end
      mcgs_pkg::ST_NB_RD: begin
        if (todo_q == '0) begin
          res_d = '0;
          res_d[7:0] = cur_q; res_d[8] = hc; res_d[9] = (cur_q[5:4] == ps_q);
          res_d[13:10] = cur_q[3:0] & exists_q; res_d[27] = 1'b1;
          st_d = mcgs_pkg::ST_OUT;
        end else begin
          nb_d = pick; todo_d = todo_q & ~sel;
          st_d = mcgs_pkg::ST_NB_WAIT;
        end
      end
      mcgs_pkg::ST_NB_WAIT: begin
        c_addr = cidx(nx, ny);
        st_d = mcgs_pkg::ST_NB_WR;
      end
      mcgs_pkg::ST_NB_WR: begin
        c_addr = cidx(nx, ny); c_we = 1'b1;
        if (cur_q[nb_q]) c_wdata = c_rdata | (8'd1 << (nb_q + 2'd2));
        else c_wdata = c_rdata & ~(8'd1 << (nb_q + 2'd2));
        st_d = mcgs_pkg::ST_NB_RD;
      end
      mcgs_pkg::ST_SRCH: begin
        if (y_q >= eh) begin
          res_d = '0; res_d[27] = vld_q; st_d = mcgs_pkg::ST_OUT;
        end else st_d = mcgs_pkg::ST_SRCH_W;
      end
      mcgs_pkg::ST_SRCH_W: begin
        if (m_rdata[0]) begin
          res_d = '0; res_d[14] = 1'b1; res_d[20:15] = x_q[5:0]; res_d[26:21] = y_q[5:0];
          res_d[27] = vld_q; st_d = mcgs_pkg::ST_OUT;
        end else begin
          if (x_q + 11'd1 >= ew) begin
            x_d = '0; y_d = y_q + 11'd1;
          end else x_d = x_q + 11'd1;
          st_d = mcgs_pkg::ST_SRCH;
        end
      end
      mcgs_pkg::ST_OUT: begin
        // move the result into the output register once it is free
        if (!ov_q || m_axis_tready) begin
          out_d = res_q; ov_d = 1'b1; st_d = mcgs_pkg::ST_IDLE;
        end
      end
      default: st_d = mcgs_pkg::ST_IDLE;
    endcase
  end

  // assertions
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (st_q == mcgs_pkg::ST_IDLE)) else $error("ready outside idle");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mcgs_pkg::ST_IDLE) |-> !c_we) else $error("memory write while idle");
  a_found_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_q[14]) |-> (11'(out_q[20:15]) < ew && 11'(out_q[26:21]) < eh))
    else $error("edge outside grid");
endmodule

[design/mcgs_ram.sv]
// generic single port ram with registered read
`timescale 1ns / 1ps
module mcgs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[test/maze_cell_grid_store_unit_tb.sv]
// self-checking testbench for the maze cell grid store unit
`timescale 1ns / 1ps
module maze_cell_grid_store_unit_tb;

  typedef struct packed {
    logic       from_start;
    logic [1:0] path;
    logic [2:0] dir;
    logic [7:0] value;
    logic [5:0] y;
    logic [5:0] x;
    logic [2:0] act;
  } cell_op_t;

  typedef struct packed {
    logic       in_grid;
    logic [5:0] edge_y;
    logic [5:0] edge_x;
    logic       edge_hit;
    logic [3:0] links;
    logic       path_match;
    logic       con_match;
    logic [7:0] cell_byte;
  } cell_report_t;

  typedef struct {
    cell_op_t     op;
    logic         fixed;
    cell_report_t want;
  } directed_row_t;

  localparam int CellCount   = 4096;
  localparam int WatchLimit  = 50000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 50;

  logic        clk_i;
  logic        rst_ni;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [6:0]  cfg_data_i;

  // grid shadow used for prediction
  logic [7:0]   grid_cells [CellCount];
  logic         grid_marks [CellCount];
  logic [6:0]   cols_reg;
  logic [6:0]   rows_reg;
  cell_report_t pending_reports [$];
  directed_row_t directed_rows [$];

  int  mismatches;
  int  idle_mode;  // 0: sender 18 / receiver 46, 1: swapped, 2: none
  bit  hold_req;
  int  hold_left;
  int  quiet_cycles;

  maze_cell_grid_store_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int used_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > 64) return 64;
    return cols_reg;
  endfunction

  function automatic int used_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > 64) return 64;
    return rows_reg;
  endfunction

  function automatic logic [3:0] neighbor_mask(int x, int y);
    logic [3:0] m;
    m = 4'd0;
    if (y > 0) m[0] = 1'b1;
    if (x + 1 < used_cols()) m[1] = 1'b1;
    if (y + 1 < used_rows()) m[2] = 1'b1;
    if (x > 0) m[3] = 1'b1;
    return m;
  endfunction

  // store a cell and mirror changed links into the neighbors
  function automatic void write_cell(int x, int y, logic [7:0] v);
    int         idx;
    int         nidx;
    logic [3:0] flips;
    logic [3:0] near;
    idx   = y * 64 + x;
    flips = grid_cells[idx][3:0] ^ v[3:0];
    near  = neighbor_mask(x, y);
    grid_cells[idx] = v;
    for (int i = 0; i < 4; i++) begin
      if (flips[i] && near[i]) begin
        case (i)
          0: nidx = idx - 64;
          1: nidx = idx + 1;
          2: nidx = idx + 64;
          default: nidx = idx - 1;
        endcase
        grid_cells[nidx][(i + 2) % 4] = v[i];
      end
    end
    grid_marks[idx] = (v[5:4] == mcgs_pkg::PATH_EDGE);
  endfunction

  function automatic logic [3:0] link_bits(logic [2:0] d);
    if (d < 3'd4) return 4'b0001 << d;
    if (d == mcgs_pkg::DIR_ALL) return 4'b1111;
    return 4'b0000;
  endfunction

  // apply one operation to the shadow grid and return its report
  function automatic cell_report_t grid_access(cell_op_t op);
    cell_report_t r;
    int           w;
    int           h;
    int           cx;
    int           cy;
    int           idx;
    logic [7:0]   cur;
    logic [3:0]   bits;
    logic         in_bounds;
    logic         found;
    w      = used_cols();
    h      = used_rows();
    r      = '0;
    in_bounds = (op.x < w) && (op.y < h);
    r.in_grid = in_bounds;
    if (op.act == mcgs_pkg::ACT_NEXT) begin
      if (!op.from_start && !in_bounds) return r;
      if (op.from_start) begin
        cx = 0;
        cy = 0;
      end else begin
        cx = op.x + 1;
        cy = op.y;
        if (cx >= w) begin
          cx = 0;
          cy = op.y + 1;
        end
      end
      found = 1'b0;
      for (; cy < h && !found; cy++) begin
        for (; cx < w && !found; cx++) begin
          if (grid_marks[cy * 64 + cx]) begin
            found    = 1'b1;
            r.edge_hit = 1'b1;
            r.edge_x = cx[5:0];
            r.edge_y = cy[5:0];
          end
        end
        cx = 0;
      end
      return r;
    end
    if (op.act == mcgs_pkg::ACT_NOP || !in_bounds) return r;
    idx  = op.y * 64 + op.x;
    cur  = grid_cells[idx];
    bits = link_bits(op.dir);
    case (op.act)
      mcgs_pkg::ACT_WRITE:  write_cell(op.x, op.y, op.value);
      mcgs_pkg::ACT_SETCON: begin
        if (op.dir == mcgs_pkg::DIR_ALL) write_cell(op.x, op.y, cur | mcgs_pkg::CON_MASK);
        else write_cell(op.x, op.y, {cur[7:4], bits});
      end
      mcgs_pkg::ACT_ADDCON: write_cell(op.x, op.y, cur | {4'd0, bits});
      mcgs_pkg::ACT_REMCON: write_cell(op.x, op.y, cur & ~{4'd0, bits});
      mcgs_pkg::ACT_SETPTH: write_cell(op.x, op.y, {cur[7:6], op.path, cur[3:0]});
      default: ;
    endcase
    cur    = grid_cells[idx];
    r.cell_byte = cur;
    if (op.dir < 3'd4) r.con_match = |(cur[3:0] & bits);
    else if (op.dir == mcgs_pkg::DIR_ALL) r.con_match = (cur[3:0] == 4'hF);
    else r.con_match = (cur[3:0] == 4'h0);
    r.path_match = (cur[5:4] == op.path);
    r.links      = cur[3:0] & neighbor_mask(op.x, op.y);
    return r;
  endfunction

  // input side: predict each accepted transaction
  logic directed_active;
  logic directed_fixed;
  cell_report_t directed_want;

  always @(posedge clk_i) begin
    cell_report_t r;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      r = grid_access(cell_op_t'(s_axis_tdata[28:0]));
      if (directed_active && directed_fixed) pending_reports.push_back(directed_want);
      else pending_reports.push_back(r);
    end
  end

  // output side: compare against the oldest expected report
  always @(posedge clk_i) begin
    cell_report_t got;
    cell_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = cell_report_t'(m_axis_tdata[27:0]);
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", got);
      end else begin
        want = pending_reports.pop_front();
        if (got.cell_byte !== want.cell_byte || got.con_match !== want.con_match ||
            got.path_match !== want.path_match || got.links !== want.links ||
            got.edge_hit !== want.edge_hit || got.edge_x !== want.edge_x ||
            got.edge_y !== want.edge_y || got.in_grid !== want.in_grid) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("maze_cell_grid_store_unit_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver with random stalls and two long hold-offs
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req      = 1'b0;
      hold_left     = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else if (idle_mode == 0) begin
      m_axis_tready = ($urandom_range(0, 99) >= 46);
    end else if (idle_mode == 1) begin
      m_axis_tready = ($urandom_range(0, 99) >= 18);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  task automatic send_op(cell_op_t op);
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 18 : ((idle_mode == 1) ? 46 : 0);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {3'd0, op};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_size(logic index, logic [6:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = value;
    if (index == 1'(mcgs_pkg::REG_WIDTH)) cols_reg = value;
    else rows_reg = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic cell_op_t random_op();
    cell_op_t op;
    int       wmax;
    int       hmax;
    wmax = (used_cols() > 63) ? 63 : used_cols();
    hmax = (used_rows() > 63) ? 63 : used_rows();
    op = cell_op_t'(29'($urandom));
    op.act = ($urandom_range(0, 99) < 3) ? mcgs_pkg::ACT_NOP : 3'($urandom_range(0, 6));
    if ($urandom_range(0, 99) < 85) begin
      op.x = 6'($urandom_range(0, wmax));
      op.y = 6'($urandom_range(0, hmax));
    end
    // favor edge marks so that searches find something
    if (op.act == mcgs_pkg::ACT_SETPTH && $urandom_range(0, 1)) op.path = mcgs_pkg::PATH_EDGE;
    return op;
  endfunction

  function automatic directed_row_t make_row(logic [2:0] act, int x, int y, logic [7:0] v,
                                            logic [2:0] d, logic [1:0] p, int fs,
                                            int fixed, cell_report_t want);
    directed_row_t row;
    row.op    = '{from_start: (fs != 0), path: p, dir: d, value: v, y: 6'(y), x: 6'(x),
                  act: act};
    row.fixed = (fixed != 0);
    row.want  = want;
    return row;
  endfunction

  // stimulus
  initial begin
    cell_report_t none;
    cell_report_t blank;
    int           total;
    int           phase_cols [8];
    int           phase_rows [8];
    int           phase_ops  [8];
    phase_cols = '{8, 0, 127, 1, 5, 3, 64, 127};
    phase_rows = '{8, 1, 1, 64, 7, 2, 64, 127};
    phase_ops  = '{520, 150, 200, 200, 400, 250, 60, 40};
    for (int i = 0; i < CellCount; i++) begin
      grid_cells[i] = 8'd0;
      grid_marks[i] = 1'b0;
    end
    cols_reg        = 7'd64;
    rows_reg        = 7'd64;
    mismatches      = 0;
    idle_mode       = 0;
    hold_req        = 1'b0;
    hold_left       = 0;
    quiet_cycles    = 0;
    directed_active = 1'b0;
    directed_fixed  = 1'b0;
    directed_want   = '0;
    rst_ni          = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tvalid   = 1'b0;
    m_axis_tready   = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = 1'b0;
    cfg_data_i      = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table, grid at reset size
    none  = '0;
    none.in_grid = 1'b1;
    blank = none;
    blank.con_match  = 1'b1;
    blank.path_match = 1'b1;
    directed_rows.push_back(make_row(mcgs_pkg::ACT_READ, 0, 0, 8'h00,
                                     mcgs_pkg::DIR_NONE, 2'd0, 0, 1, blank));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_NEXT, 0, 0, 8'h00,
                                     mcgs_pkg::DIR_N, 2'd0, 1, 1, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_NOP, 5, 5, 8'h00,
                                     mcgs_pkg::DIR_N, 2'd0, 0, 1, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_WRITE, 0, 0, 8'hFF,
                                     mcgs_pkg::DIR_ALL, 2'd3, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_WRITE, 63, 63, 8'hFF,
                                     mcgs_pkg::DIR_N, 2'd3, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_READ, 63, 63, 8'h00,
                                     mcgs_pkg::DIR_ALL, 2'd3, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_SETCON, 10, 10, 8'h00,
                                     mcgs_pkg::DIR_N, 2'd0, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_SETCON, 10, 10, 8'h00,
                                     mcgs_pkg::DIR_ALL, 2'd0, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_ADDCON, 10, 10, 8'h00,
                                     mcgs_pkg::DIR_E, 2'd1, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_REMCON, 10, 10, 8'h00,
                                     mcgs_pkg::DIR_S, 2'd0, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_REMCON, 10, 10, 8'h00,
                                     3'd7, 2'd0, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_SETCON, 10, 10, 8'h00,
                                     3'd6, 2'd0, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_SETPTH, 20, 5, 8'h00,
                                     mcgs_pkg::DIR_W, 2'd2, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_SETPTH, 63, 0, 8'h00,
                                     mcgs_pkg::DIR_N, 2'd2, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_NEXT, 0, 0, 8'h00,
                                     mcgs_pkg::DIR_N, 2'd0, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_NEXT, 20, 5, 8'h00,
                                     mcgs_pkg::DIR_N, 2'd0, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_NEXT, 63, 63, 8'h00,
                                     mcgs_pkg::DIR_N, 2'd0, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_SETPTH, 63, 0, 8'h00,
                                     mcgs_pkg::DIR_N, 2'd3, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_WRITE, 0, 63, 8'h20,
                                     mcgs_pkg::DIR_W, 2'd2, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_NEXT, 62, 0, 8'h00,
                                     mcgs_pkg::DIR_N, 2'd0, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_READ, 0, 63, 8'h00,
                                     mcgs_pkg::DIR_W, 2'd2, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_REMCON, 63, 63, 8'h00,
                                     mcgs_pkg::DIR_ALL, 2'd0, 0, 0, none));
    directed_rows.push_back(make_row(mcgs_pkg::ACT_ADDCON, 0, 0, 8'h00,
                                     mcgs_pkg::DIR_W, 2'd3, 0, 0, none));
    directed_active = 1'b1;
    foreach (directed_rows[i]) begin
      // change the expected row away from the sampling edge
      @(negedge clk_i);
      directed_fixed = directed_rows[i].fixed;
      directed_want  = directed_rows[i].want;
      send_op(directed_rows[i].op);
    end
    wait_drained();
    directed_active = 1'b0;

    // random phases over several grid sizes, extremes among them
    total = 0;
    foreach (phase_ops[p]) begin
      write_size(1'(mcgs_pkg::REG_WIDTH), 7'(phase_cols[p]));
      write_size(1'(mcgs_pkg::REG_HEIGHT), 7'(phase_rows[p]));
      for (int n = 0; n < phase_ops[p]; n++) begin
        idle_mode = (total < 620) ? 0 : ((total < 1240) ? 1 : 2);
        if (total == 100 || total == 1300) hold_req = 1'b1;
        if (total == 300) wait_drained();
        send_op(random_op());
        total++;
      end
      wait_drained();
    end

    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("maze_cell_grid_store_unit_tb OK");
    end else begin
      $display("maze_cell_grid_store_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
